// ----- hw/rtl/arm_data_processing_encoder_core_defines.svh -----
// assertion macros for the data-processing encoder
`ifndef ARM_DATA_PROCESSING_ENCODER_CORE_DEFINES_SVH
`define ARM_DATA_PROCESSING_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define ADPE_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("adpe same-cycle check failed");

// next-cycle implication
`define ADPE_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("adpe next-cycle check failed");

`endif

// ----- hw/rtl/adpe_pkg.sv -----
package adpe_pkg;

    localparam logic [3:0] COND_ALWAYS = 4'd14;
    localparam logic [3:0] MOVE_OPCODE = 4'd13;
    localparam int         ROT_COUNT   = 15;

    localparam logic [1:0] MODE_COMPUTE = 2'd0;
    localparam logic [1:0] MODE_MOVE    = 2'd1;
    localparam logic [1:0] MODE_TEST    = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_NO_IMM  = 2'd2;

    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_EOR = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_RSB = 3'd3;
    localparam logic [2:0] OP_ADD = 3'd4;
    localparam logic [2:0] OP_ORR = 3'd5;

    localparam logic [2:0] OP_TST = 3'd0;
    localparam logic [2:0] OP_TEQ = 3'd1;
    localparam logic [2:0] OP_CMP = 3'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  op;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic        is_immediate;
        logic [31:0] imm_value;
        logic [3:0]  shifted_reg;
        logic [1:0]  shift_kind;
        logic        shift_by_register;
        logic [3:0]  amount_reg;
        logic [4:0]  shift_count;
    } adpe_in_t;

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [1:0]  error_code;
    } adpe_out_t;

    function automatic logic [3:0] compute_opcode(input logic [2:0] op);
        logic [3:0] code;
        case (op)
            OP_AND:  code = 4'd0;
            OP_EOR:  code = 4'd1;
            OP_SUB:  code = 4'd2;
            OP_RSB:  code = 4'd3;
            OP_ADD:  code = 4'd4;
            OP_ORR:  code = 4'd12;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] test_opcode(input logic [2:0] op);
        logic [3:0] code;
        case (op)
            OP_TST:  code = 4'd8;
            OP_TEQ:  code = 4'd9;
            OP_CMP:  code = 4'd10;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/arm_data_processing_encoder_core.sv -----
// Encodes one data-processing instruction word per transaction. A transaction is
// taken on any clock edge with start high; busy is always low, so a new
// transaction can be issued every cycle. done is high with the result on result
// after the accepted command has passed the input register and then the result
// register (one input register, one result register around the encoding logic,
// including the parallel rotation search).
// The receiver cannot stall: result is valid only during the done cycle and
// must be captured then. Errors return a zero word with a nonzero error_code.
`include "arm_data_processing_encoder_core_defines.svh"

module arm_data_processing_encoder_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  adpe_pkg::adpe_in_t cmd,
    output logic               done,
    output adpe_pkg::adpe_out_t result
);
    import adpe_pkg::*;

    logic      st_valid_reg;
    adpe_in_t  cmd_reg;
    logic      done_reg;
    adpe_out_t result_reg;
    adpe_out_t result_next;

    logic [31:0]         word;
    logic [1:0]          err;
    logic [31:0]         rot [ROT_COUNT];
    logic [ROT_COUNT-1:0] fits;
    logic [ROT_COUNT-1:0] run_end;
    logic [ROT_COUNT-1:0] sel;
    logic [7:0]          imm_byte;
    logic [4:0]          rot_field;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            st_valid_reg <= start && !busy;
            done_reg     <= st_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        if (st_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // rotation search over right rotations 2..30
    always_comb
    begin
        for (int i = 0; i < ROT_COUNT; i++)
        begin
            rot[i]  = (cmd_reg.imm_value >> (2 * (i + 1)))
                    | (cmd_reg.imm_value << (32 - 2 * (i + 1)));
            fits[i] = (rot[i][31:8] == 24'd0);
        end
        // end of each run of fits, then keep the first one
        run_end = fits & ~{1'b0, fits[ROT_COUNT-1:1]};
        sel     = run_end & (~run_end + ROT_COUNT'(1));
        imm_byte  = 8'd0;
        rot_field = 5'd0;
        for (int i = 0; i < ROT_COUNT; i++)
        begin
            if (sel[i])
            begin
                imm_byte  = imm_byte | rot[i][7:0];
                rot_field = rot_field | 5'(32 - 2 * (i + 1));
            end
        end
    end

    always_comb
    begin
        word = {COND_ALWAYS, 28'd0};
        err  = ERR_NONE;
        case (cmd_reg.mode)
            MODE_COMPUTE:
            begin
                word[24:21] = compute_opcode(cmd_reg.op);
                word[15:12] = cmd_reg.dest_reg;
                word[19:16] = cmd_reg.first_reg;
            end
            MODE_MOVE:
            begin
                word[24:21] = MOVE_OPCODE;
                word[15:12] = cmd_reg.dest_reg;
            end
            MODE_TEST:
            begin
                word[24:21] = test_opcode(cmd_reg.op);
                word[19:16] = cmd_reg.first_reg;
                word[20]    = 1'b1;
            end
            default:
            begin
                err = ERR_ILLEGAL;
            end
        endcase

        if (cmd_reg.is_immediate)
        begin
            word[25] = 1'b1;
            if (cmd_reg.imm_value[31:8] != 24'd0)
            begin
                if (|fits)
                begin
                    word[7:0]  = imm_byte;
                    word[11:7] = word[11:7] | rot_field;
                end
                else if (err == ERR_NONE)
                begin
                    err = ERR_NO_IMM;
                end
            end
            else
            begin
                word[7:0] = cmd_reg.imm_value[7:0];
            end
        end
        else
        begin
            word[3:0] = cmd_reg.shifted_reg;
            word[6:5] = cmd_reg.shift_kind;
            if (cmd_reg.shift_by_register)
            begin
                word[4]    = 1'b1;
                word[11:8] = cmd_reg.amount_reg;
            end
            else
            begin
                word[11:7] = cmd_reg.shift_count;
            end
        end

        result_next.instruction_word = (err == ERR_NONE) ? word : 32'd0;
        result_next.error_code       = err;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ADPE_ASSERT_NEXT(a_accept_loads, start, st_valid_reg)
    `ADPE_ASSERT_NEXT(a_stage_to_done, st_valid_reg, done)
    `ADPE_ASSERT_NOW(a_zero_on_error, done, (result.error_code == ERR_NONE) == (result.instruction_word != 32'd0))
    `ADPE_ASSERT_NOW(a_cond_field, done && (result.error_code == ERR_NONE), result.instruction_word[31:28] == COND_ALWAYS)

endmodule
